// ----- design/bcmp_pkg.sv -----
// Shared definitions for the binomial coefficient modulo prime block:
// the prime, Barrett reduction constants, the Fermat exponent and the
// request/response structs of the modular multiplier. No dependencies.
`default_nettype none

package bcmp_pkg;

   // Operand and result width: every residue is below the prime and fits 30 bits
   localparam int VAL_W = 30;
   // Width of n, k and the factorial index
   localparam int IDX_W = 16;

   localparam logic [VAL_W-1:0] P_MOD = 30'd1000000007;
   localparam logic [IDX_W-1:0] MAX_N = 16'd65535;

   // Barrett reduction: mu = floor(2^60 / p), 31 bits wide
   localparam logic [62:0] MU_FULL    = (63'd1 << 60) / {33'd0, P_MOD};
   localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

   // Residue correction bounds (remainder estimate stays below 3p < 2^32)
   localparam logic [31:0] P_MOD_32 = {2'b00, P_MOD};
   localparam logic [31:0] P_MOD_X2 = {1'b0, P_MOD, 1'b0};

   // Fermat inverse exponent p-2, scanned from bit 0 up to its top bit
   localparam int              EXP_BITS = 30;
   localparam logic [VAL_W-1:0] EXP_E   = P_MOD - 30'd2;
   localparam logic [4:0]       EXP_LAST = 5'(EXP_BITS - 1);

   typedef struct packed {
      logic             valid;
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             valid;
      logic [VAL_W-1:0] value;
   } mul_rsp_type;

endpackage

`default_nettype wire

// ----- design/bcmp_mulmod.sv -----
// Pipelined modular multiplier: (a * b) mod p with Barrett reduction,
// four register stages, one new operation per cycle. Uses bcmp_pkg.
`default_nettype none

module bcmp_mulmod import bcmp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   logic             s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [59:0]      s1_prod_ff, s1_prod_in;
   logic [VAL_W-1:0] s2_quot_ff, s2_quot_in;
   logic [31:0]      s2_low_ff;
   logic [31:0]      s3_rem_ff, s3_rem_in;
   logic [VAL_W-1:0] s4_res_ff, s4_res_in;
   logic [61:0]      est_full;
   logic [59:0]      qp_full;

   always_comb begin
      // full product, below p^2 < 2^60
      s1_prod_in = 60'(mul_req.a) * 60'(mul_req.b);
      // quotient estimate, at most two below the true quotient
      est_full   = 62'(s1_prod_ff[59:29]) * 62'(BARRETT_MU);
      s2_quot_in = est_full[60:31];
      // remainder estimate needs only the low 32 bits
      qp_full    = 60'(s2_quot_ff) * 60'(P_MOD);
      s3_rem_in  = s2_low_ff - qp_full[31:0];
      // drop at most two multiples of p
      if (s3_rem_ff >= P_MOD_X2) begin
         s4_res_in = 30'(s3_rem_ff - P_MOD_X2);
      end else if (s3_rem_ff >= P_MOD_32) begin
         s4_res_in = 30'(s3_rem_ff - P_MOD_32);
      end else begin
         s4_res_in = s3_rem_ff[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= mul_req.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      s1_prod_ff <= s1_prod_in;
      s2_quot_ff <= s2_quot_in;
      s2_low_ff  <= s1_prod_ff[31:0];
      s3_rem_ff  <= s3_rem_in;
      s4_res_ff  <= s4_res_in;
   end

   assign mul_rsp.valid = s4_valid_ff;
   assign mul_rsp.value = s4_res_ff;

endmodule

`default_nettype wire

// ----- design/binomial_coefficient_mod_prime.sv -----
// Binomial coefficient C(n,k) modulo 1000000007: top level with the sequencer.
// Depends on bcmp_pkg and on the shared multiplier bcmp_mulmod.
//
// Usage:
//   An item enters on req_valid/req_stall with req_n_total and req_k_choose;
//   it is taken at a clock edge where req_valid is high and req_stall low.
//   One result item leaves on rsp_valid/rsp_stall with rsp_binomial_value and
//   rsp_k_exceeds_n. req_stall stays high from acceptance until the result
//   has been taken, so one item is in the block at a time.
//   All arithmetic runs through one four-stage modular multiplier. The
//   factorial sweep issues one multiplication each time the previous one
//   leaves the pipeline. If k > n the flag is set and the value is zero,
//   with no arithmetic.
//   k! and (n-k)! are captured on the way to n!; their product is inverted
//   once by square-and-multiply to the power p-2 (15 multiplies, 29 squares).
//   While rsp_stall is high the result holds on the output registers and no
//   new item is taken. Synchronous reset returns the sequencer to idle and
//   empties the multiplier pipeline; no clearing pass is needed.
`default_nettype none

module binomial_coefficient_mod_prime import bcmp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [IDX_W-1:0] req_n_total,
   input  logic [IDX_W-1:0] req_k_choose,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [VAL_W-1:0] rsp_binomial_value,
   output logic             rsp_k_exceeds_n
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FACT,
      ST_DEN_GO,
      ST_DEN_WAIT,
      ST_EXP_MUL_GO,
      ST_EXP_MUL_WAIT,
      ST_EXP_SQR_GO,
      ST_EXP_SQR_WAIT,
      ST_FIN_GO,
      ST_FIN_WAIT,
      ST_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] nk_ff, nk_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [VAL_W-1:0] acc_ff, acc_in;     // running factorial, ends as n!
   logic [VAL_W-1:0] fk_ff, fk_in;       // k!
   logic [VAL_W-1:0] fnk_ff, fnk_in;     // (n-k)!
   logic [VAL_W-1:0] base_ff, base_in;   // repeated square of the denominator
   logic [VAL_W-1:0] pw_ff, pw_in;       // partial power, ends as the inverse
   logic [4:0]       bit_ff, bit_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic             flag_ff, flag_in;

   logic [IDX_W-1:0] n_sat;
   logic [IDX_W-1:0] idx_next;
   mul_req_type      mul_req;
   mul_rsp_type      mul_rsp;

   bcmp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // n is clamped to the sweep limit before anything else, the k test included
   assign n_sat    = (req_n_total > MAX_N) ? MAX_N : req_n_total;
   assign idx_next = idx_ff + 16'd1;

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      nk_in    = nk_ff;
      idx_in   = idx_ff;
      acc_in   = acc_ff;
      fk_in    = fk_ff;
      fnk_in   = fnk_ff;
      base_in  = base_ff;
      pw_in    = pw_ff;
      bit_in   = bit_ff;
      value_in = value_ff;
      flag_in  = flag_ff;
      mul_req  = '{valid: 1'b0, a: '0, b: '0};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in   = n_sat;
               k_in   = req_k_choose;
               nk_in  = n_sat - req_k_choose;
               idx_in = '0;
               acc_in = 30'd1;
               // 0! = 1 covers k = 0 and k = n without a capture
               fk_in  = 30'd1;
               fnk_in = 30'd1;
               if (req_k_choose > n_sat) begin
                  value_in = '0;
                  flag_in  = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  flag_in = 1'b0;
                  if (n_sat == '0) begin
                     state_in = ST_DEN_GO;
                  end else begin
                     mul_req  = '{valid: 1'b1, a: 30'd1, b: 30'd1};
                     idx_in   = 16'd1;
                     state_in = ST_FACT;
                  end
               end
            end
         end

         ST_FACT: begin
            // result is idx!: capture it, then chain the next factor at once
            if (mul_rsp.valid) begin
               acc_in = mul_rsp.value;
               if (idx_ff == k_ff) begin
                  fk_in = mul_rsp.value;
               end
               if (idx_ff == nk_ff) begin
                  fnk_in = mul_rsp.value;
               end
               if (idx_ff == n_ff) begin
                  state_in = ST_DEN_GO;
               end else begin
                  mul_req = '{valid: 1'b1, a: mul_rsp.value, b: 30'(idx_next)};
                  idx_in  = idx_next;
               end
            end
         end

         ST_DEN_GO: begin
            mul_req  = '{valid: 1'b1, a: fk_ff, b: fnk_ff};
            state_in = ST_DEN_WAIT;
         end

         ST_DEN_WAIT: begin
            if (mul_rsp.valid) begin
               base_in  = mul_rsp.value;
               pw_in    = 30'd1;
               bit_in   = '0;
               state_in = ST_EXP_MUL_GO;
            end
         end

         ST_EXP_MUL_GO: begin
            if (EXP_E[bit_ff]) begin
               mul_req  = '{valid: 1'b1, a: pw_ff, b: base_ff};
               state_in = ST_EXP_MUL_WAIT;
            end else begin
               state_in = ST_EXP_SQR_GO;
            end
         end

         ST_EXP_MUL_WAIT: begin
            if (mul_rsp.valid) begin
               pw_in    = mul_rsp.value;
               state_in = ST_EXP_SQR_GO;
            end
         end

         ST_EXP_SQR_GO: begin
            // skip the square after the top exponent bit
            if (bit_ff == EXP_LAST) begin
               state_in = ST_FIN_GO;
            end else begin
               mul_req  = '{valid: 1'b1, a: base_ff, b: base_ff};
               state_in = ST_EXP_SQR_WAIT;
            end
         end

         ST_EXP_SQR_WAIT: begin
            if (mul_rsp.valid) begin
               base_in  = mul_rsp.value;
               bit_in   = bit_ff + 5'd1;
               state_in = ST_EXP_MUL_GO;
            end
         end

         ST_FIN_GO: begin
            mul_req  = '{valid: 1'b1, a: acc_ff, b: pw_ff};
            state_in = ST_FIN_WAIT;
         end

         ST_FIN_WAIT: begin
            if (mul_rsp.valid) begin
               value_in = mul_rsp.value;
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            // hold the result until the receiver takes it
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff     <= n_in;
      k_ff     <= k_in;
      nk_ff    <= nk_in;
      idx_ff   <= idx_in;
      acc_ff   <= acc_in;
      fk_ff    <= fk_in;
      fnk_ff   <= fnk_in;
      base_ff  <= base_in;
      pw_ff    <= pw_in;
      bit_ff   <= bit_in;
      value_ff <= value_in;
      flag_ff  <= flag_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = (state_ff == ST_RESP);
   assign rsp_binomial_value = value_ff;
   assign rsp_k_exceeds_n    = flag_ff;

   // A pending result keeps the input side closed
   a_busy_while_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result is pending");

   // The flagged case always carries a zero value
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_k_exceeds_n) |-> (rsp_binomial_value == '0))
      else $error("k above n with nonzero value");

   // Every delivered value is a reduced residue
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_binomial_value < P_MOD))
      else $error("result not reduced modulo p");

   // Multiplier results arrive only while the sequencer waits for one
   a_mul_expected: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.valid |-> (state_ff == ST_FACT || state_ff == ST_DEN_WAIT ||
                         state_ff == ST_EXP_MUL_WAIT || state_ff == ST_EXP_SQR_WAIT ||
                         state_ff == ST_FIN_WAIT))
      else $error("unexpected multiplier result");

endmodule

`default_nettype wire
